[rtl/rfi_pkg.sv]
`timescale 1ns / 1ps

package rfi_pkg;

  localparam int unsigned NumWords   = 4;
  localparam int unsigned WordBits   = 648;
  localparam int unsigned SoftWidth  = 16;
  localparam int unsigned ValueWidth = 16;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned TopBit     = 7;
  localparam int unsigned IndexWidth = 2;

  localparam int unsigned FrameLen = NumWords * WordBits;
  localparam int unsigned NumBytes = (FrameLen + TopBit) / ByteBits;

  localparam int unsigned AddrW   = $clog2(FrameLen);
  localparam int unsigned PosW    = $clog2(WordBits + 1);
  localparam int unsigned CwW     = $clog2(NumWords);
  localparam int unsigned KW      = $clog2(ByteBits + 1);
  localparam int unsigned BitSelW = $clog2(ByteBits);

  localparam longint SoftMax = (64'sd1 <<< (SoftWidth - 1)) - 64'sd1;
  localparam longint SoftMin = -SoftMax - 64'sd1;

  typedef enum logic [1:0] {
    MODE_HARD       = 2'd0,
    MODE_SOFT_INT   = 2'd1,
    MODE_SOFT_DEINT = 2'd2,
    MODE_UNUSED     = 2'd3
  } mode_e;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpFetch = 1'b1;

  typedef logic signed [SoftWidth-1:0] soft_t;

  function automatic soft_t sat_soft(input logic signed [ValueWidth-1:0] v);
    longint w;
    w = longint'(v);
    if (w > SoftMax) begin
      return SoftWidth'(SoftMax);
    end else if (w < SoftMin) begin
      return SoftWidth'(SoftMin);
    end
    return SoftWidth'(w);
  endfunction

endpackage

[rtl/rfi_ram.sv]
`timescale 1ns / 1ps

module rfi_ram #(
  parameter int unsigned Depth = 2592,
  parameter int unsigned Width = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rotated_frame_interleaver_core.sv]
`timescale 1ns / 1ps

// Rotated block interleaver for a frame of four codewords of 648 elements, held in one
// single-port-write, registered-read frame store; every load writes the store at its
// permuted address and fetches read it back in order. The single store port sets the
// rate: a soft load is one store write, a hard byte load one write per bit, and a
// codeword_end a zero write per unwritten position of its codeword. A soft fetch is one
// read, a hard byte fetch eight bit reads; each blocks requests until its result reaches
// the output register. Loads are dropped while a finished frame is unread; a fetch with
// no frame gives valid 0. The store is not cleared at reset: only full frames are read.
module rotated_frame_interleaver_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [1:0]                            cfg_data_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // Fields from bit 0: value.
  input  logic signed [rfi_pkg::ValueWidth-1:0] s_axis_tdata,
  // Fields from bit 0: op.
  input  logic                                  s_axis_tuser,
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // Fields from bit 0: result_value.
  output logic [rfi_pkg::ValueWidth-1:0]        m_axis_tdata,
  // Fields from bit 0: valid_res, codeword_index.
  output logic [rfi_pkg::IndexWidth:0]          m_axis_tuser,
  output logic                                  m_axis_tlast
);

  import rfi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HARD_LOAD,
    ST_PAD,
    ST_HARD_READ,
    ST_SOFT_READ,
    ST_RESULT
  } state_e;

  state_e                 state_q, state_d;
  mode_e                  mode_q, mode_d;
  logic [CwW-1:0]         cw_q, cw_d;
  logic [PosW-1:0]        pos_q, pos_d;
  logic [CwW-1:0]         rot_q, rot_d;
  logic [CwW-1:0]         bm_q, bm_d;
  logic                   frame_ready_q, frame_ready_d;
  logic [AddrW-1:0]       fetch_q, fetch_d;
  logic [PosW-1:0]        fpos_q, fpos_d;
  logic [CwW-1:0]         fcw_q, fcw_d;
  logic [ByteBits-1:0]    byte_q, byte_d;
  logic                   cend_q, cend_d;
  logic [KW-1:0]          k_q, k_d;
  logic                   rd_ok_q, rd_ok_d;
  logic                   res_valid_q, res_valid_d;
  logic [ValueWidth-1:0]  res_value_q, res_value_d;
  logic                   res_last_q, res_last_d;
  logic [IndexWidth-1:0]  res_cwi_q, res_cwi_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_vres_q, out_vres_d;
  logic [ValueWidth-1:0]  out_value_q, out_value_d;
  logic                   out_last_q, out_last_d;
  logic [IndexWidth-1:0]  out_cwi_q, out_cwi_d;

  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr;
  soft_t                  ram_wdata;
  logic [AddrW-1:0]       ram_raddr;
  soft_t                  ram_rdata;

  logic                   pos_lt;
  logic [CwW-1:0]         rot_inc;
  logic [CwW:0]           deint_cw;
  logic [AddrW-1:0]       perm_addr;
  logic [AddrW-1:0]       deint_addr;
  logic [AddrW+BitSelW-1:0] hard_full;
  logic                   hard_ok;
  logic [ByteBits-1:0]    next_byte;
  logic                   fetch_last;

  rfi_ram #(
    .Depth (FrameLen),
    .Width (SoftWidth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    cw_d          = cw_q;
    pos_d         = pos_q;
    rot_d         = rot_q;
    bm_d          = bm_q;
    frame_ready_d = frame_ready_q;
    fetch_d       = fetch_q;
    fpos_d        = fpos_q;
    fcw_d         = fcw_q;
    byte_d        = byte_q;
    cend_d        = cend_q;
    k_d           = k_q;
    rd_ok_d       = rd_ok_q;
    res_valid_d   = res_valid_q;
    res_value_d   = res_value_q;
    res_last_d    = res_last_q;
    res_cwi_d     = res_cwi_q;
    out_valid_d   = out_valid_q;
    out_vres_d    = out_vres_q;
    out_value_d   = out_value_q;
    out_last_d    = out_last_q;
    out_cwi_d     = out_cwi_q;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = fetch_q;
    next_byte     = byte_q;
    fetch_last    = 1'b0;

    pos_lt     = pos_q < PosW'(WordBits);
    rot_inc    = (rot_q == CwW'(NumWords - 1)) ? '0 : rot_q + 1'b1;
    deint_cw   = (rot_q >= bm_q) ? ({1'b0, rot_q} - {1'b0, bm_q})
                                 : ({1'b0, rot_q} + (CwW+1)'(NumWords) - {1'b0, bm_q});
    perm_addr  = AddrW'(pos_q) * AddrW'(NumWords) + AddrW'(rot_q);
    deint_addr = AddrW'(deint_cw[CwW-1:0]) * AddrW'(WordBits) + AddrW'(pos_q);
    hard_full  = {fetch_q, k_q[BitSelW-1:0]};
    hard_ok    = hard_full < (AddrW+BitSelW)'(FrameLen);

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == OpLoad) begin
            if (!frame_ready_q) begin
              unique case (mode_q)
                MODE_HARD: begin
                  byte_d  = s_axis_tdata[ByteBits-1:0];
                  cend_d  = s_axis_tlast;
                  k_d     = '0;
                  state_d = ST_HARD_LOAD;
                end
                MODE_SOFT_INT: begin
                  if (pos_lt) begin
                    ram_we    = 1'b1;
                    ram_waddr = perm_addr;
                    ram_wdata = sat_soft(s_axis_tdata);
                    pos_d     = pos_q + 1'b1;
                    rot_d     = rot_inc;
                  end
                  if (s_axis_tlast) begin
                    state_d = ST_PAD;
                  end
                end
                MODE_SOFT_DEINT: begin
                  ram_we    = 1'b1;
                  ram_waddr = deint_addr;
                  ram_wdata = sat_soft(s_axis_tdata);
                  if (rot_q == CwW'(NumWords - 1)) begin
                    rot_d = '0;
                    bm_d  = (bm_q == CwW'(NumWords - 1)) ? '0 : bm_q + 1'b1;
                    if (pos_q == PosW'(WordBits - 1)) begin
                      pos_d         = '0;
                      bm_d          = '0;
                      frame_ready_d = 1'b1;
                      fetch_d       = '0;
                      fpos_d        = '0;
                      fcw_d         = '0;
                    end else begin
                      pos_d = pos_q + 1'b1;
                    end
                  end else begin
                    rot_d = rot_q + 1'b1;
                  end
                end
                default: begin
                end
              endcase
            end
          end else begin
            if (!frame_ready_q || mode_q == MODE_UNUSED) begin
              res_valid_d = 1'b0;
              res_value_d = '0;
              res_last_d  = 1'b0;
              res_cwi_d   = '0;
              state_d     = ST_RESULT;
            end else if (mode_q == MODE_HARD) begin
              k_d     = '0;
              byte_d  = '0;
              state_d = ST_HARD_READ;
            end else begin
              ram_raddr = fetch_q;
              state_d   = ST_SOFT_READ;
            end
          end
        end
      end

      ST_HARD_LOAD: begin
        byte_d = {byte_q[ByteBits-2:0], 1'b0};
        if (pos_lt) begin
          ram_we       = 1'b1;
          ram_waddr    = perm_addr;
          ram_wdata    = '0;
          ram_wdata[0] = byte_q[TopBit];
          pos_d        = pos_q + 1'b1;
          rot_d        = rot_inc;
        end
        k_d = k_q + 1'b1;
        if (k_q == KW'(TopBit)) begin
          state_d = cend_q ? ST_PAD : ST_IDLE;
        end
      end

      ST_PAD: begin
        if (pos_lt) begin
          ram_we    = 1'b1;
          ram_waddr = perm_addr;
          ram_wdata = '0;
          pos_d     = pos_q + 1'b1;
          rot_d     = rot_inc;
        end else begin
          pos_d   = '0;
          state_d = ST_IDLE;
          if (cw_q == CwW'(NumWords - 1)) begin
            cw_d          = '0;
            rot_d         = '0;
            frame_ready_d = 1'b1;
            fetch_d       = '0;
            fpos_d        = '0;
            fcw_d         = '0;
          end else begin
            cw_d  = cw_q + 1'b1;
            rot_d = cw_q + 1'b1;
          end
        end
      end

      ST_HARD_READ: begin
        if (k_q != '0) begin
          next_byte = {byte_q[ByteBits-2:0], rd_ok_q & ram_rdata[0]};
          byte_d    = next_byte;
        end
        if (k_q == KW'(ByteBits)) begin
          fetch_last  = fetch_q == AddrW'(NumBytes - 1);
          res_valid_d = 1'b1;
          res_value_d = ValueWidth'(next_byte);
          res_last_d  = fetch_last;
          res_cwi_d   = '0;
          if (fetch_last) begin
            fetch_d       = '0;
            frame_ready_d = 1'b0;
          end else begin
            fetch_d = fetch_q + 1'b1;
          end
          state_d = ST_RESULT;
        end else begin
          ram_raddr = hard_full[AddrW-1:0];
          rd_ok_d   = hard_ok;
          k_d       = k_q + 1'b1;
        end
      end

      ST_SOFT_READ: begin
        fetch_last  = fetch_q == AddrW'(FrameLen - 1);
        res_valid_d = 1'b1;
        res_value_d = ValueWidth'(ram_rdata);
        res_last_d  = fetch_last;
        res_cwi_d   = (mode_q == MODE_SOFT_DEINT) ? IndexWidth'(fcw_q) : '0;
        if (fetch_last) begin
          fetch_d       = '0;
          fpos_d        = '0;
          fcw_d         = '0;
          frame_ready_d = 1'b0;
        end else begin
          fetch_d = fetch_q + 1'b1;
          if (fpos_q == PosW'(WordBits - 1)) begin
            fpos_d = '0;
            fcw_d  = fcw_q + 1'b1;
          end else begin
            fpos_d = fpos_q + 1'b1;
          end
        end
        state_d = ST_RESULT;
      end

      ST_RESULT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_vres_d  = res_valid_q;
          out_value_d = res_value_q;
          out_last_d  = res_last_q;
          out_cwi_d   = res_cwi_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_valid_i) begin
      mode_d        = mode_e'(cfg_data_i);
      cw_d          = '0;
      pos_d         = '0;
      rot_d         = '0;
      bm_d          = '0;
      frame_ready_d = 1'b0;
      fetch_d       = '0;
      fpos_d        = '0;
      fcw_d         = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      mode_q        <= MODE_HARD;
      cw_q          <= '0;
      pos_q         <= '0;
      rot_q         <= '0;
      bm_q          <= '0;
      frame_ready_q <= 1'b0;
      fetch_q       <= '0;
      fpos_q        <= '0;
      fcw_q         <= '0;
      byte_q        <= '0;
      cend_q        <= 1'b0;
      k_q           <= '0;
      rd_ok_q       <= 1'b0;
      res_valid_q   <= 1'b0;
      res_value_q   <= '0;
      res_last_q    <= 1'b0;
      res_cwi_q     <= '0;
      out_valid_q   <= 1'b0;
      out_vres_q    <= 1'b0;
      out_value_q   <= '0;
      out_last_q    <= 1'b0;
      out_cwi_q     <= '0;
    end else begin
      state_q       <= state_d;
      mode_q        <= mode_d;
      cw_q          <= cw_d;
      pos_q         <= pos_d;
      rot_q         <= rot_d;
      bm_q          <= bm_d;
      frame_ready_q <= frame_ready_d;
      fetch_q       <= fetch_d;
      fpos_q        <= fpos_d;
      fcw_q         <= fcw_d;
      byte_q        <= byte_d;
      cend_q        <= cend_d;
      k_q           <= k_d;
      rd_ok_q       <= rd_ok_d;
      res_valid_q   <= res_valid_d;
      res_value_q   <= res_value_d;
      res_last_q    <= res_last_d;
      res_cwi_q     <= res_cwi_d;
      out_valid_q   <= out_valid_d;
      out_vres_q    <= out_vres_d;
      out_value_q   <= out_value_d;
      out_last_q    <= out_last_d;
      out_cwi_q     <= out_cwi_d;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = {out_cwi_q, out_vres_q};
  assign m_axis_tlast  = out_last_q;

  // A finished frame is never overwritten before it has been read out.
  a_no_write_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_ready_q |-> !ram_we)
    else $error("frame store written while a finished frame is unread");

  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr < AddrW'(FrameLen)))
    else $error("frame store write address out of range");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(WordBits))
    else $error("load position past the codeword length");

  a_result_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT && (!out_valid_q || m_axis_tready)) |=> m_axis_tvalid)
    else $error("fetch result not presented on the output");

endmodule

[verif/rotated_frame_interleaver_core_test.sv]
`timescale 1ns / 1ps

module rotated_frame_interleaver_core_test;
  import rfi_pkg::*;

  localparam int unsigned CycleLimit   = 3_000_000;
  localparam int unsigned SettleCycles = 800;
  localparam int          NoLongWord   = 4;

  typedef struct packed {
    logic                  valid_res;
    logic [ValueWidth-1:0] value;
    logic                  frame_last;
    logic [IndexWidth-1:0] cw_idx;
  } fetch_res_t;

  typedef enum logic [1:0] {
    ROW_LOAD        = 2'd0,
    ROW_FETCH       = 2'd1,
    ROW_FETCH_EMPTY = 2'd2,
    ROW_MODE        = 2'd3
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [ValueWidth-1:0] value;
    logic                  cend;
  } stim_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_data_i    = 2'd0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [ValueWidth-1:0] s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [ValueWidth-1:0] m_axis_tdata;
  logic [IndexWidth:0]   m_axis_tuser;
  logic                  m_axis_tlast;

  rotated_frame_interleaver_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Expected state of the interleaver.
  soft_t       frame_mem [FrameLen];
  mode_e       cur_mode  = MODE_HARD;
  int unsigned ld_cw     = 0;
  int unsigned ld_pos    = 0;
  int unsigned rd_pos    = 0;
  bit          frm_ready = 1'b0;

  fetch_res_t  fetch_results_q [$];
  stim_row_t   dir_tab [$];
  bit          idle_en       = 1'b1;
  int          stall_left    = 0;
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen  = 0;
  int unsigned frames_done   = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic soft_t clamp_to_soft(input logic signed [ValueWidth-1:0] v);
    longint hi;
    longint lo;
    longint w;
    hi = (64'sd1 <<< (SoftWidth - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    w  = longint'(v);
    if (w > hi) begin
      w = hi;
    end else if (w < lo) begin
      w = lo;
    end
    return soft_t'(w);
  endfunction

  function automatic int unsigned il_addr(input int unsigned cw, input int unsigned pos);
    return pos * NumWords + (cw + pos) % NumWords;
  endfunction

  function automatic logic [ValueWidth-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return ValueWidth'($urandom);
    endcase
  endfunction

  function automatic stim_row_t mk(input row_kind_e k, input logic [ValueWidth-1:0] v,
                                   input logic c);
    stim_row_t r;
    r.kind  = k;
    r.value = v;
    r.cend  = c;
    return r;
  endfunction

  task automatic store_elem(input soft_t v);
    if (ld_cw < NumWords && ld_pos < WordBits) begin
      frame_mem[il_addr(ld_cw, ld_pos)] = v;
    end
    if (ld_pos < WordBits) begin
      ld_pos++;
    end
  endtask

  task automatic close_codeword();
    while (ld_pos < WordBits) begin
      if (ld_cw < NumWords) begin
        frame_mem[il_addr(ld_cw, ld_pos)] = '0;
      end
      ld_pos++;
    end
    ld_pos = 0;
    ld_cw++;
    if (ld_cw >= NumWords) begin
      ld_cw     = 0;
      frm_ready = 1'b1;
      rd_pos    = 0;
    end
  endtask

  task automatic store_deint(input soft_t v);
    int unsigned idx;
    int unsigned pos;
    int unsigned cw;
    idx = ld_cw * WordBits + ld_pos;
    if (idx < FrameLen) begin
      pos = idx / NumWords;
      cw  = (idx % NumWords + NumWords - pos % NumWords) % NumWords;
      frame_mem[cw * WordBits + pos] = v;
    end
    ld_pos++;
    if (ld_pos >= WordBits) begin
      ld_pos = 0;
      ld_cw++;
      if (ld_cw >= NumWords) begin
        ld_cw     = 0;
        frm_ready = 1'b1;
        rd_pos    = 0;
      end
    end
  endtask

  task automatic interleaver_step(input logic op, input logic [ValueWidth-1:0] raw,
                                  input logic cend, output bit gives_res,
                                  output fetch_res_t res);
    soft_t       sv;
    logic [7:0]  acc;
    int unsigned p;
    res       = '0;
    gives_res = (op == OpFetch);
    sv        = clamp_to_soft(signed'(raw));
    if (op == OpLoad) begin
      if (frm_ready || cur_mode == MODE_UNUSED) begin
        return;
      end
      case (cur_mode)
        MODE_HARD: begin
          for (int b = TopBit; b >= 0; b--) begin
            store_elem(soft_t'(raw[b]));
          end
          if (cend) begin
            close_codeword();
          end
        end
        MODE_SOFT_INT: begin
          store_elem(sv);
          if (cend) begin
            close_codeword();
          end
        end
        default: begin
          store_deint(sv);
        end
      endcase
      return;
    end
    if (!frm_ready || cur_mode == MODE_UNUSED) begin
      return;
    end
    res.valid_res = 1'b1;
    if (cur_mode == MODE_HARD) begin
      acc = '0;
      for (int k = 0; k < ByteBits; k++) begin
        p = rd_pos * ByteBits + k;
        if (p < FrameLen) begin
          acc[TopBit-k] = frame_mem[p][0];
        end
      end
      res.value = ValueWidth'(acc);
      if (rd_pos + 1 >= NumBytes) begin
        res.frame_last = 1'b1;
        frm_ready      = 1'b0;
        rd_pos         = 0;
      end else begin
        rd_pos++;
      end
    end else begin
      p         = (rd_pos < FrameLen) ? rd_pos : FrameLen - 1;
      res.value = frame_mem[p];
      if (cur_mode == MODE_SOFT_DEINT) begin
        res.cw_idx = IndexWidth'(p / WordBits);
      end
      if (p + 1 >= FrameLen) begin
        res.frame_last = 1'b1;
        frm_ready      = 1'b0;
        rd_pos         = 0;
      end else begin
        rd_pos = p + 1;
      end
    end
  endtask

  task automatic send_request(input logic op, input logic [ValueWidth-1:0] v,
                              input logic cend, input bit typed_empty);
    bit         has_res;
    fetch_res_t want;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= v;
    s_axis_tlast  <= cend;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    requests_sent++;
    interleaver_step(op, v, cend, has_res, want);
    if (has_res) begin
      fetch_results_q.push_back(typed_empty ? fetch_res_t'('0) : want);
    end
  endtask

  task automatic write_mode(input mode_e m);
    s_axis_tvalid <= 1'b0;
    while (fetch_results_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_data_i  <= m;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_mode  = m;
    ld_cw     = 0;
    ld_pos    = 0;
    rd_pos    = 0;
    frm_ready = 1'b0;
  endtask

  task automatic noise_fetch(input int unsigned odds);
    if ($urandom_range(1, odds) == 1) begin
      send_request(OpFetch, ValueWidth'($urandom), 1'($urandom), 1'b0);
    end
  endtask

  task automatic run_phase(input mode_e m, input bit full_read, input int long_cw,
                           input bit broken);
    int unsigned n_cw;
    int unsigned n;
    int unsigned n_rd;
    write_mode(m);
    if (m == MODE_UNUSED) begin
      repeat (20) begin
        send_request(1'($urandom), rand_value(), 1'($urandom), 1'b0);
      end
      return;
    end
    repeat ($urandom_range(0, 2)) send_request(OpFetch, rand_value(), 1'($urandom), 1'b0);
    if (m == MODE_SOFT_DEINT) begin
      n = full_read ? FrameLen : $urandom_range(8, 40);
      for (int i = 0; i < n; i++) begin
        noise_fetch(16);
        send_request(OpLoad, rand_value(), 1'($urandom), 1'b0);
      end
    end else begin
      n_cw = broken ? $urandom_range(1, NumWords - 1) : NumWords;
      for (int cw = 0; cw < n_cw; cw++) begin
        if (cw == long_cw) begin
          n = (m == MODE_HARD) ? $urandom_range(WordBits / ByteBits - 1, WordBits / ByteBits + 2)
                               : $urandom_range(WordBits - 2, WordBits + 2);
        end else begin
          n = $urandom_range(1, 6);
        end
        for (int j = 0; j < n; j++) begin
          noise_fetch(10);
          send_request(OpLoad, rand_value(), (j == n - 1), 1'b0);
        end
      end
      if (broken) begin
        repeat ($urandom_range(0, 3)) send_request(OpLoad, rand_value(), 1'b0, 1'b0);
      end
    end
    if (!broken) begin
      repeat ($urandom_range(0, 2)) send_request(OpLoad, rand_value(), 1'($urandom), 1'b0);
      if (full_read) begin
        n_rd = ((m == MODE_HARD) ? NumBytes : FrameLen) + $urandom_range(1, 3);
      end else begin
        n_rd = $urandom_range(1, 40);
      end
      repeat (n_rd) send_request(OpFetch, rand_value(), 1'($urandom), 1'b0);
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_left    <= $urandom_range(0, 18);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    fetch_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (fetch_results_q.size() == 0) begin
        $error("result with no request outstanding: tdata %h tuser %b tlast %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        want = fetch_results_q.pop_front();
        if (want.valid_res && want.frame_last) begin
          frames_done++;
        end
        if (m_axis_tuser[0] !== want.valid_res) begin
          $error("valid_res expected %0d actual %0d", want.valid_res, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tdata !== want.value) begin
          $error("result_value expected %h actual %h", want.value, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== want.frame_last) begin
          $error("frame_last expected %0d actual %0d", want.frame_last, m_axis_tlast);
          mismatches++;
        end
        if (m_axis_tuser[IndexWidth:1] !== want.cw_idx) begin
          $error("codeword_index expected %0d actual %0d", want.cw_idx,
                 m_axis_tuser[IndexWidth:1]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
             fetch_results_q.size());
      $display("rotated_frame_interleaver_core test failed");
      $finish;
    end
  end

  initial begin
    foreach (frame_mem[i]) frame_mem[i] = '0;

    dir_tab.push_back(mk(ROW_FETCH_EMPTY, 16'h0000, 1'b0));
    dir_tab.push_back(mk(ROW_LOAD, 16'h00FF, 1'b0));
    dir_tab.push_back(mk(ROW_LOAD, 16'h0000, 1'b0));
    dir_tab.push_back(mk(ROW_LOAD, 16'hFF00, 1'b0));
    dir_tab.push_back(mk(ROW_LOAD, 16'h7FFF, 1'b1));
    dir_tab.push_back(mk(ROW_LOAD, 16'h8001, 1'b1));
    dir_tab.push_back(mk(ROW_LOAD, 16'hFFFF, 1'b1));
    dir_tab.push_back(mk(ROW_LOAD, 16'h00A5, 1'b1));
    dir_tab.push_back(mk(ROW_LOAD, 16'h0055, 1'b1));
    dir_tab.push_back(mk(ROW_FETCH, 16'h0000, 1'b0));
    dir_tab.push_back(mk(ROW_FETCH, 16'hFFFF, 1'b1));
    dir_tab.push_back(mk(ROW_FETCH, 16'h0000, 1'b0));
    dir_tab.push_back(mk(ROW_MODE, ValueWidth'(MODE_SOFT_INT), 1'b0));
    dir_tab.push_back(mk(ROW_FETCH_EMPTY, 16'h0000, 1'b0));
    dir_tab.push_back(mk(ROW_LOAD, 16'h7FFF, 1'b0));
    dir_tab.push_back(mk(ROW_LOAD, 16'h8000, 1'b1));
    dir_tab.push_back(mk(ROW_LOAD, 16'h0000, 1'b1));
    dir_tab.push_back(mk(ROW_LOAD, 16'hFFFF, 1'b1));
    dir_tab.push_back(mk(ROW_LOAD, 16'h0001, 1'b1));
    dir_tab.push_back(mk(ROW_FETCH, 16'h0000, 1'b0));
    dir_tab.push_back(mk(ROW_FETCH, 16'h0000, 1'b0));
    dir_tab.push_back(mk(ROW_MODE, ValueWidth'(MODE_UNUSED), 1'b0));
    dir_tab.push_back(mk(ROW_LOAD, 16'h1234, 1'b1));
    dir_tab.push_back(mk(ROW_FETCH_EMPTY, 16'h0000, 1'b0));
    dir_tab.push_back(mk(ROW_MODE, ValueWidth'(MODE_SOFT_DEINT), 1'b0));
    dir_tab.push_back(mk(ROW_FETCH_EMPTY, 16'h0000, 1'b0));
    dir_tab.push_back(mk(ROW_LOAD, 16'h8000, 1'b1));
    dir_tab.push_back(mk(ROW_FETCH_EMPTY, 16'hFFFF, 1'b1));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_MODE:        write_mode(mode_e'(dir_tab[i].value[1:0]));
        ROW_FETCH_EMPTY: send_request(OpFetch, dir_tab[i].value, dir_tab[i].cend, 1'b1);
        ROW_FETCH:       send_request(OpFetch, dir_tab[i].value, dir_tab[i].cend, 1'b0);
        default:         send_request(OpLoad, dir_tab[i].value, dir_tab[i].cend, 1'b0);
      endcase
    end

    run_phase(MODE_HARD, 1'b0, $urandom_range(0, NumWords - 1), 1'b0);
    run_phase(MODE_SOFT_INT, 1'b0, NoLongWord, 1'b0);
    run_phase(MODE_SOFT_DEINT, 1'b0, NoLongWord, 1'b0);
    run_phase(MODE_HARD, 1'b0, NoLongWord, 1'b1);
    run_phase(MODE_UNUSED, 1'b0, NoLongWord, 1'b0);
    run_phase(MODE_SOFT_INT, 1'b0, NoLongWord, 1'b1);
    idle_en <= 1'b0;
    run_phase(MODE_HARD, 1'b1, $urandom_range(0, NumWords - 1), 1'b0);
    run_phase(MODE_SOFT_INT, 1'b0, NoLongWord, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (fetch_results_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fetch_results_q.size() != 0) begin
      $error("%0d expected results never arrived", fetch_results_q.size());
      mismatches++;
    end

    $display("Sent %0d requests in all four modes and checked %0d results,", requests_sent,
             results_seen);
    $display("with %0d frames read out to their last element.", frames_done);
    if (mismatches == 0) begin
      $display("rotated_frame_interleaver_core test passed");
    end else begin
      $display("rotated_frame_interleaver_core test failed");
    end
    $finish;
  end

endmodule
